### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/kdl_pkg.sv
// Types and constants of the key debounce / long-press latch block.
`default_nettype none

package kdl_pkg;

   localparam int unsigned CSR_INDEX_WIDTH  = 2;
   localparam int unsigned CSR_DATA_WIDTH   = 16;
   localparam int unsigned STABLE_WIDTH     = 8;
   localparam int unsigned HOLD_WIDTH       = 12;
   localparam int unsigned PERIOD_CFG_WIDTH = 16;

   localparam logic [STABLE_WIDTH-1:0]     STABLE_RESET = 8'd5;
   localparam logic [HOLD_WIDTH-1:0]       LONG_RESET   = 12'd100;
   localparam logic [PERIOD_CFG_WIDTH-1:0] SLOW_RESET   = 16'd100;
   localparam logic [PERIOD_CFG_WIDTH-1:0] FAST_RESET   = 16'd20;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STABLE_COUNT     = 2'd0,
      CSR_LONG_PRESS_COUNT = 2'd1,
      CSR_SLOW_PERIOD      = 2'd2,
      CSR_FAST_PERIOD      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_WAIT_PRESS   = 2'd0,
      PH_PRESS_DB     = 2'd1,
      PH_WAIT_RELEASE = 2'd2,
      PH_RELEASE_DB   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_PRESS        = 2'd1,
      EV_RELEASE      = 2'd2,
      EV_LONG_RELEASE = 2'd3
   } event_type;

   typedef struct packed {
      logic [STABLE_WIDTH-1:0]     stable_count;
      logic [HOLD_WIDTH-1:0]       long_press_count;
      logic [PERIOD_CFG_WIDTH-1:0] slow_period;
      logic [PERIOD_CFG_WIDTH-1:0] fast_period;
   } cfg_type;

   // Next values of the pin-side outputs, loaded into the result register.
   typedef struct packed {
      logic led_level;
      logic power_hold;
      logic fast_mode;
   } pin_type;

endpackage

`default_nettype wire

### rtl/core/kdl_debounce.sv
// Four-phase button debouncer with hold counter and long-press flag.
`default_nettype none

module kdl_debounce (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             pressed,
   input  kdl_pkg::cfg_type      cfg,
   output kdl_pkg::event_type    event_in
);

   kdl_pkg::phase_type                  phase_ff, phase_in;
   logic [kdl_pkg::STABLE_WIDTH-1:0]    dbc_ff, dbc_in, dbc_bump;
   logic [kdl_pkg::HOLD_WIDTH-1:0]      hold_ff, hold_in, hold_bump;
   logic                                long_ff, long_in;

   // saturating bumps
   assign dbc_bump  = (dbc_ff != '1) ? dbc_ff + 8'd1 : dbc_ff;
   assign hold_bump = (hold_ff < cfg.long_press_count) ? hold_ff + 12'd1 : hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kdl_pkg::PH_WAIT_PRESS;
         dbc_ff   <= '0;
         hold_ff  <= '0;
         long_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         dbc_ff   <= dbc_in;
         hold_ff  <= hold_in;
         long_ff  <= long_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      dbc_in   = dbc_ff;
      hold_in  = hold_ff;
      long_in  = long_ff;
      event_in = kdl_pkg::EV_NONE;
      case (phase_ff)
         kdl_pkg::PH_WAIT_PRESS: begin
            if (pressed) begin
               dbc_in   = '0;
               phase_in = kdl_pkg::PH_PRESS_DB;
            end
         end
         kdl_pkg::PH_PRESS_DB: begin
            dbc_in = dbc_bump;
            if (pressed) begin
               if (dbc_bump >= cfg.stable_count) begin
                  event_in = kdl_pkg::EV_PRESS;
                  hold_in  = '0;
                  long_in  = 1'b0;
                  phase_in = kdl_pkg::PH_WAIT_RELEASE;
               end
            end else begin
               phase_in = kdl_pkg::PH_WAIT_PRESS;
            end
         end
         kdl_pkg::PH_WAIT_RELEASE: begin
            hold_in = hold_bump;
            if (!pressed) begin
               if (hold_bump >= cfg.long_press_count) begin
                  long_in = 1'b1;
               end
               dbc_in   = '0;
               phase_in = kdl_pkg::PH_RELEASE_DB;
            end
         end
         kdl_pkg::PH_RELEASE_DB: begin
            dbc_in = dbc_bump;
            if (!pressed) begin
               if (dbc_bump >= cfg.stable_count) begin
                  event_in = long_ff ? kdl_pkg::EV_LONG_RELEASE : kdl_pkg::EV_RELEASE;
                  phase_in = kdl_pkg::PH_WAIT_PRESS;
               end
            end else begin
               // bounce: back to waiting, hold count and flag kept
               phase_in = kdl_pkg::PH_WAIT_RELEASE;
            end
         end
         default: begin
            phase_in = kdl_pkg::PH_WAIT_PRESS;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/kdl_blink.sv
// Blink timer, LED pin levels, fast/slow select and power latch.
`default_nettype none

module kdl_blink #(
   parameter int unsigned PERIOD_WIDTH = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  kdl_pkg::event_type  event_in,
   input  kdl_pkg::cfg_type    cfg,
   output kdl_pkg::pin_type    pin_in
);

   localparam int unsigned CMP_WIDTH =
      (PERIOD_WIDTH > kdl_pkg::PERIOD_CFG_WIDTH) ? PERIOD_WIDTH : kdl_pkg::PERIOD_CFG_WIDTH;

   logic [PERIOD_WIDTH-1:0]              bc_ff, bc_in, bc_bump;
   logic [kdl_pkg::PERIOD_CFG_WIDTH-1:0] period;
   logic                                 fast_ff, fast_in;
   logic                                 pin_ff, pin_lvl_in;
   logic                                 nxt_ff, nxt_in;
   logic                                 pwr_ff, pwr_in;
   logic                                 wrap;

   assign period  = fast_ff ? cfg.fast_period : cfg.slow_period;
   assign bc_bump = (bc_ff != '1) ? bc_ff + PERIOD_WIDTH'(1) : bc_ff;
   assign wrap    = (CMP_WIDTH'(bc_bump) >= CMP_WIDTH'(period)) || (bc_bump == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff   <= '0;
         fast_ff <= 1'b0;
         pin_ff  <= 1'b0;
         nxt_ff  <= 1'b0;
         pwr_ff  <= 1'b1;
      end else if (step) begin
         bc_ff   <= bc_in;
         fast_ff <= fast_in;
         pin_ff  <= pin_lvl_in;
         nxt_ff  <= nxt_in;
         pwr_ff  <= pwr_in;
      end
   end

   always_comb begin
      bc_in      = bc_bump;
      fast_in    = fast_ff;
      pin_lvl_in = pin_ff;
      nxt_in     = nxt_ff;
      pwr_in     = pwr_ff;
      if (event_in == kdl_pkg::EV_RELEASE) begin
         // short release: swap rate, restart timer, no LED update
         fast_in = ~fast_ff;
         bc_in   = '0;
      end else begin
         if (event_in == kdl_pkg::EV_LONG_RELEASE) begin
            pwr_in = 1'b0;
         end
         if (wrap) begin
            bc_in      = '0;
            pin_lvl_in = nxt_ff;
            nxt_in     = ~nxt_ff;
         end
      end
      pin_in.led_level  = pin_lvl_in;
      pin_in.power_hold = pwr_in;
      pin_in.fast_mode  = fast_in;
   end

endmodule

`default_nettype wire

### rtl/core/key_debounce_long_press_latch.sv
// Top level of the key debounce / long-press latch block.
// Usage:
//  - req channel: one word per button sample tick, req_pressed = 1 when pressed.
//  - rsp channel: one word per sample: event code (none, press, short release,
//    long-press release), LED pin level, power-hold level and fast-mode flag.
//  - csr channel: register writes (stable count, long-press count, slow and
//    fast blink periods); always ready, write only while the block is idle.
//  - A sample accepted at a clock edge loads the rsp register at that edge; its
//    word can be taken in the next cycle at the earliest.
//  - Throughput: one sample per cycle unless rsp stalls; the state update is one
//    pass of counters and compares from the state registers to the rsp register.
//  - Stall: the rsp register holds its word while rsp_ready is low; a new
//    sample is taken in the same cycle the held word leaves, so req_ready
//    is low only while a word waits and rsp_ready is low.
//  - Reset: debouncer waits for a press, counters clear, slow blink, LED low,
//    power latch held, config registers go to their defaults, rsp empty.
//  - After a long-press release power_hold stays low until reset.
`default_nettype none

module key_debounce_long_press_latch #(
   parameter int unsigned PERIOD_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // sample input
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_pressed,
   // result output
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_btn_event,
   output logic                                      rsp_led_level,
   output logic                                      rsp_power_hold,
   output logic                                      rsp_fast_mode,
   // config writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kdl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [kdl_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   kdl_pkg::cfg_type    cfg_ff;
   kdl_pkg::event_type  event_in;
   kdl_pkg::pin_type    pin_in;
   logic                step;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_event_ff;
   kdl_pkg::pin_type    rsp_pin_ff;

   // accept a sample whenever the rsp register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_count     <= kdl_pkg::STABLE_RESET;
         cfg_ff.long_press_count <= kdl_pkg::LONG_RESET;
         cfg_ff.slow_period      <= kdl_pkg::SLOW_RESET;
         cfg_ff.fast_period      <= kdl_pkg::FAST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (kdl_pkg::csr_index_type'(csr_index))
            kdl_pkg::CSR_STABLE_COUNT:
               cfg_ff.stable_count <= csr_wdata[kdl_pkg::STABLE_WIDTH-1:0];
            kdl_pkg::CSR_LONG_PRESS_COUNT:
               cfg_ff.long_press_count <= csr_wdata[kdl_pkg::HOLD_WIDTH-1:0];
            kdl_pkg::CSR_SLOW_PERIOD:
               cfg_ff.slow_period <= csr_wdata[kdl_pkg::PERIOD_CFG_WIDTH-1:0];
            kdl_pkg::CSR_FAST_PERIOD:
               cfg_ff.fast_period <= csr_wdata[kdl_pkg::PERIOD_CFG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   kdl_debounce u_debounce (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .pressed  (req_pressed),
      .cfg      (cfg_ff),
      .event_in (event_in)
   );

   kdl_blink #(
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_blink (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .event_in (event_in),
      .cfg      (cfg_ff),
      .pin_in   (pin_in)
   );

   // rsp register: valid tracks words in flight, payload loads on accept
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_ff <= event_in;
         rsp_pin_ff   <= pin_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_btn_event  = rsp_event_ff;
   assign rsp_led_level  = rsp_pin_ff.led_level;
   assign rsp_power_hold = rsp_pin_ff.power_hold;
   assign rsp_fast_mode  = rsp_pin_ff.fast_mode;

endmodule

`default_nettype wire

### rtl/core/kdl_checker.sv
// Port-level checker for the key debounce / long-press latch block, with bind.
`default_nettype none
`include "assert_macros.svh"

module kdl_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_btn_event,
   input wire logic       rsp_led_level,
   input wire logic       rsp_power_hold,
   input wire logic       rsp_fast_mode
);

   // stalled word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_btn_event, rsp_led_level, rsp_power_hold, rsp_fast_mode}))

   // power latch only drops
   `ASSERT_NEXT(a_power_once, clock, reset, rsp_valid && !rsp_power_hold, !rsp_power_hold)

   // long-press release drops power in the same word
   `ASSERT_IMPLIES(a_long_drops, clock, reset, rsp_valid && (rsp_btn_event == kdl_pkg::EV_LONG_RELEASE), !rsp_power_hold)

   // blink rate only changes on a short release
   `ASSERT_NEXT(a_fast_toggle, clock, reset, rsp_valid && rsp_ready, !rsp_valid || (rsp_fast_mode == $past(rsp_fast_mode)) || (rsp_btn_event == kdl_pkg::EV_RELEASE))

endmodule

bind key_debounce_long_press_latch kdl_port_checker u_kdl_port_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_btn_event  (rsp_btn_event),
   .rsp_led_level  (rsp_led_level),
   .rsp_power_hold (rsp_power_hold),
   .rsp_fast_mode  (rsp_fast_mode)
);

`default_nettype wire

### tb/kdl_checker.sv
`timescale 1ns / 1ps
// Checker that tracks the key debounce block, predicts each result word and compares it.
module kdl_checker #(
   parameter int unsigned PERIOD_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_pressed,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [1:0]                          rsp_btn_event,
   input  logic                                rsp_led_level,
   input  logic                                rsp_power_hold,
   input  logic                                rsp_fast_mode,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [kdl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kdl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int unsigned                         fail_count,
   output int unsigned                         pending_words
);

   typedef struct packed {
      kdl_pkg::event_type btn_event;
      logic               led_level;
      logic               power_hold;
      logic               fast_mode;
   } key_word_type;

   localparam logic [PERIOD_WIDTH-1:0] BLINK_TOP = '1;

   // register copies
   logic [kdl_pkg::STABLE_WIDTH-1:0]     stable_cfg;
   logic [kdl_pkg::HOLD_WIDTH-1:0]       long_cfg;
   logic [kdl_pkg::PERIOD_CFG_WIDTH-1:0] slow_cfg;
   logic [kdl_pkg::PERIOD_CFG_WIDTH-1:0] fast_cfg;

   // predicted block state
   kdl_pkg::phase_type                   phase_q;
   logic [7:0]                           settle_count;
   logic [kdl_pkg::HOLD_WIDTH-1:0]       hold_count;
   logic                                 long_seen;
   logic [PERIOD_WIDTH-1:0]              blink_count;
   logic                                 fast_sel;
   logic                                 pin_level;
   logic                                 next_level;
   logic                                 power_on;

   key_word_type expected_words[$];

   // One sample tick: debouncer, then mode / power / blink update.
   task automatic debounce_tick(input logic pressed, output key_word_type word);
      kdl_pkg::event_type                   btn_event;
      logic                                 restart;
      logic [kdl_pkg::PERIOD_CFG_WIDTH-1:0] period;
      btn_event = kdl_pkg::EV_NONE;
      restart   = 1'b0;
      case (phase_q)
         kdl_pkg::PH_WAIT_PRESS: begin
            if (pressed) begin
               settle_count = '0;
               phase_q      = kdl_pkg::PH_PRESS_DB;
            end
         end
         kdl_pkg::PH_PRESS_DB: begin
            if (settle_count != 8'hFF) settle_count++;
            if (!pressed) begin
               phase_q = kdl_pkg::PH_WAIT_PRESS;
            end else if (settle_count >= stable_cfg) begin
               btn_event  = kdl_pkg::EV_PRESS;
               hold_count = '0;
               long_seen  = 1'b0;
               phase_q    = kdl_pkg::PH_WAIT_RELEASE;
            end
         end
         kdl_pkg::PH_WAIT_RELEASE: begin
            if (hold_count < long_cfg) hold_count++;
            if (!pressed) begin
               if (hold_count >= long_cfg) long_seen = 1'b1;
               settle_count = '0;
               phase_q      = kdl_pkg::PH_RELEASE_DB;
            end
         end
         default: begin
            if (settle_count != 8'hFF) settle_count++;
            if (pressed) begin
               phase_q = kdl_pkg::PH_WAIT_RELEASE;
            end else if (settle_count >= stable_cfg) begin
               btn_event = long_seen ? kdl_pkg::EV_LONG_RELEASE : kdl_pkg::EV_RELEASE;
               phase_q   = kdl_pkg::PH_WAIT_PRESS;
            end
         end
      endcase

      if (btn_event == kdl_pkg::EV_LONG_RELEASE) begin
         power_on = 1'b0;
      end else if (btn_event == kdl_pkg::EV_RELEASE) begin
         fast_sel    = ~fast_sel;
         blink_count = '0;
         restart     = 1'b1;
      end

      if (!restart) begin
         period = fast_sel ? fast_cfg : slow_cfg;
         if (blink_count != BLINK_TOP) blink_count++;
         if (blink_count >= period || blink_count == BLINK_TOP) begin
            blink_count = '0;
            pin_level   = next_level;
            next_level  = ~next_level;
         end
      end

      word.btn_event  = btn_event;
      word.led_level  = pin_level;
      word.power_hold = power_on;
      word.fast_mode  = fast_sel;
   endtask

   always @(posedge clock) begin : track
      key_word_type want;
      if (reset) begin
         stable_cfg   = kdl_pkg::STABLE_RESET;
         long_cfg     = kdl_pkg::LONG_RESET;
         slow_cfg     = kdl_pkg::SLOW_RESET;
         fast_cfg     = kdl_pkg::FAST_RESET;
         phase_q      = kdl_pkg::PH_WAIT_PRESS;
         settle_count = '0;
         hold_count   = '0;
         long_seen    = 1'b0;
         blink_count  = '0;
         fast_sel     = 1'b0;
         pin_level    = 1'b0;
         next_level   = 1'b0;
         power_on     = 1'b1;
         expected_words.delete();
      end else begin
         // results first: a word leaving now belongs to an earlier sample
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("rsp word with no sample pending");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_btn_event !== want.btn_event) begin
                  $error("btn_event: expected %0d, actual %0d", want.btn_event, rsp_btn_event);
                  fail_count++;
               end
               if (rsp_led_level !== want.led_level) begin
                  $error("led_level: expected %0d, actual %0d", want.led_level, rsp_led_level);
                  fail_count++;
               end
               if (rsp_power_hold !== want.power_hold) begin
                  $error("power_hold: expected %0d, actual %0d", want.power_hold,
                         rsp_power_hold);
                  fail_count++;
               end
               if (rsp_fast_mode !== want.fast_mode) begin
                  $error("fast_mode: expected %0d, actual %0d", want.fast_mode, rsp_fast_mode);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kdl_pkg::CSR_STABLE_COUNT:
                  stable_cfg = csr_wdata[kdl_pkg::STABLE_WIDTH-1:0];
               kdl_pkg::CSR_LONG_PRESS_COUNT:
                  long_cfg   = csr_wdata[kdl_pkg::HOLD_WIDTH-1:0];
               kdl_pkg::CSR_SLOW_PERIOD:
                  slow_cfg   = csr_wdata[kdl_pkg::PERIOD_CFG_WIDTH-1:0];
               kdl_pkg::CSR_FAST_PERIOD:
                  fast_cfg   = csr_wdata[kdl_pkg::PERIOD_CFG_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            debounce_tick(req_pressed, want);
            expected_words.push_back(want);
         end
      end
      pending_words = expected_words.size();
   end

endmodule

### tb/key_debounce_long_press_latch_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives samples and register writes into the debounce block and gives the verdict.
module key_debounce_long_press_latch_tb;

   // Run length guard.
   localparam int unsigned CYCLE_LIMIT    = 200000;
   // Receiver hold-off long enough to back the block up into req_ready.
   localparam int unsigned HOLD_OFF_TICKS = 60;
   // Extra cycles after the last word, to catch stray results.
   localparam int unsigned DRAIN_TICKS    = 4;

   // Fixed opening sequence, stable 1 / long 3: press, release bounce, long
   // release (drops power), press bounce, then a short release.
   localparam logic [0:17] DIRECTED_KEYS = 18'b011101110010110000;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_pressed;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [1:0]                          rsp_btn_event;
   logic                                rsp_led_level;
   logic                                rsp_power_hold;
   logic                                rsp_fast_mode;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [kdl_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [kdl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   int unsigned fail_count;
   int unsigned pending_words;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned words_sent;
   int unsigned cycle_count;
   int unsigned cur_stable;
   int unsigned cur_long;
   bit          hold_off_request;

   key_debounce_long_press_latch i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pressed    (req_pressed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_btn_event  (rsp_btn_event),
      .rsp_led_level  (rsp_led_level),
      .rsp_power_hold (rsp_power_hold),
      .rsp_fast_mode  (rsp_fast_mode),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   kdl_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pressed    (req_pressed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_btn_event  (rsp_btn_event),
      .rsp_led_level  (rsp_led_level),
      .rsp_power_hold (rsp_power_hold),
      .rsp_fast_mode  (rsp_fast_mode),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_words  (pending_words)
   );

   always #10 clock = ~clock;

   // Run-away guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("key_debounce_long_press_latch_tb: done, errors");
         $finish;
      end
   end

   // Result side. Random back-pressure at recv_idle_pct; on request a long
   // hold-off, counted here, while the sender keeps offering words.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_TICKS) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // One sample word. Entered and left at a falling edge; valid stays high
   // on exit so back-to-back words keep it up without a dip.
   task automatic send_key(input logic pressed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pressed <= pressed;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      words_sent++;
   endtask

   // Stop offering and wait until every predicted word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
   endtask

   task automatic write_csr(input kdl_pkg::csr_index_type idx,
                            input logic [kdl_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
   endtask

   // Registers only change with the block idle. Upper data bits beyond a
   // register's width are don't-care and get exercised too.
   task automatic load_settings(input logic [kdl_pkg::CSR_DATA_WIDTH-1:0] stable, long_press,
                                input logic [kdl_pkg::CSR_DATA_WIDTH-1:0] slow, fast);
      drain();
      write_csr(kdl_pkg::CSR_STABLE_COUNT, stable);
      write_csr(kdl_pkg::CSR_LONG_PRESS_COUNT, long_press);
      write_csr(kdl_pkg::CSR_SLOW_PERIOD, slow);
      write_csr(kdl_pkg::CSR_FAST_PERIOD, fast);
      csr_valid  <= 1'b0;
      cur_stable = stable[kdl_pkg::STABLE_WIDTH-1:0];
      cur_long   = long_press[kdl_pkg::HOLD_WIDTH-1:0];
   endtask

   // One button gesture. Mostly a clean press / hold / release sized to the
   // current settings (with occasional bounces on either edge), the rest
   // short glitches and plain noise.
   task automatic key_gesture();
      int unsigned kind;
      int unsigned hold;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         // short press bounce before the full press
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) send_key(1'b1);
            send_key(1'b0);
         end
         repeat (cur_stable + 2 + $urandom_range(0, 1)) send_key(1'b1);
         // half short holds, half reaching around the long-press mark
         hold = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, cur_long + 3);
         repeat (hold) send_key(1'b1);
         // release bounce: back to holding, count kept
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, cur_stable)) send_key(1'b0);
            send_key(1'b1);
         end
         repeat (cur_stable + 2 + $urandom_range(0, 2)) send_key(1'b0);
      end else if (kind < 9) begin
         repeat ($urandom_range(1, 3)) send_key(1'b1);
         repeat ($urandom_range(1, 3)) send_key(1'b0);
      end else begin
         repeat ($urandom_range(1, 12)) send_key(1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pressed = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = kdl_pkg::CSR_STABLE_COUNT;
      csr_wdata   = '0;
      cur_stable  = kdl_pkg::STABLE_RESET;
      cur_long    = kdl_pkg::LONG_RESET;
      // idling: sender light, receiver heavy
      send_idle_pct = 29;
      recv_idle_pct = 86;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults as they come out of reset
      repeat (2) key_gesture();

      // directed edge cases on tight settings
      load_settings(16'd1, 16'd3, 16'd2, 16'd1);
      for (int i = 0; i < $bits(DIRECTED_KEYS); i++) send_key(DIRECTED_KEYS[i]);

      // small counts so long presses and blinks happen often; junk upper bits
      load_settings(16'hA502, 16'hF00C, 16'd7, 16'd3);
      repeat (8) key_gesture();
      hold_off_request = 1'b1;
      while (words_sent < 360) key_gesture();

      // idling swapped: sender heavy, receiver light
      send_idle_pct = 86;
      recv_idle_pct = 29;

      // all-zero settings: instant accept, every press long, blink every tick
      load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      while (words_sent < 520) key_gesture();

      // top of every register range; too slow for gestures, noise only
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (30) send_key(1'($urandom_range(0, 1)));

      // no idling at all, one more receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(16'h5A03, 16'hA014, 16'd25, 16'd9);
      repeat (5) key_gesture();
      hold_off_request = 1'b1;
      while (words_sent < 840) key_gesture();

      drain();
      repeat (DRAIN_TICKS) @(posedge clock);
      if (fail_count == 0)
         $display("key_debounce_long_press_latch_tb: done, clean");
      else
         $display("key_debounce_long_press_latch_tb: done, errors");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/kdl_pkg.sv
rtl/core/kdl_debounce.sv
rtl/core/kdl_blink.sv
rtl/core/key_debounce_long_press_latch.sv
rtl/core/kdl_checker.sv
tb/kdl_checker.sv
tb/key_debounce_long_press_latch_tb.sv
